// ===== hw/rtl/lrutc_pkg.sv =====
// ----------------------------------------------------------------------------
// lrutc_pkg
// Shared sizes and transaction types of the LRU tag cache directory.
// ----------------------------------------------------------------------------
package lrutc_pkg;

  localparam int unsigned Entries   = 16;
  localparam int unsigned TagBits   = 32;
  localparam int unsigned IdxW      = $clog2(Entries);
  localparam int unsigned CntW      = $clog2(Entries + 1);
  localparam int unsigned SlotOutW  = 4;

  typedef struct packed {
    logic [TagBits-1:0] name_tag;
    logic               fetch_ok;
  } req_t;

  typedef struct packed {
    logic                hit;
    logic                inserted;
    logic                evicted;
    logic                failed;
    logic [SlotOutW-1:0] slot;
  } rsp_t;

  // Result of the parallel tag compare and victim search.
  typedef struct packed {
    logic            hit;
    logic [IdxW-1:0] hit_idx;
    logic [IdxW-1:0] victim_idx;
  } lookup_t;

endpackage

// ===== hw/rtl/lru_tag_cache_policy.sv =====
// ----------------------------------------------------------------------------
// lru_tag_cache_policy
// Fully associative 16-entry tag directory with least-recently-used
// replacement; one lookup/update per transaction.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------
//  req     | in        | req_valid_i/req_stall_o | req_i (name_tag, fetch_ok)
//  rsp     | out       | rsp_valid_o/rsp_stall_i | rsp_o (hit, inserted,
//          |           |                         |  evicted, failed, slot)
//
// One transaction per cycle sustained while rsp is not stalled. A request is
// captured in the input register, then looked up and applied to the directory
// as its response is written to the output register.
// The rate is set by the single-cycle compare/rank-update path.
// Reset clears the valid bits and the fill count at once; no clearing pass.
// While rsp is stalled with a full output register, the input register holds
// and req_stall_o rises once that register is occupied.
// ----------------------------------------------------------------------------
module lru_tag_cache_policy import lrutc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_stall_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_stall_i,
  output rsp_t rsp_o
);

  localparam logic [CntW-1:0] CntFull = CntW'(Entries);

  // Input register
  logic in_valid_q;
  req_t in_q;

  // Output register
  logic rsp_valid_q;
  rsp_t rsp_q, rsp_d;

  // Directory state
  logic [Entries-1:0]              valid_q, valid_d;
  logic [Entries-1:0][TagBits-1:0] tags_q;
  logic [Entries-1:0][IdxW-1:0]    ranks_q, ranks_d;
  logic [CntW-1:0]                 fill_q, fill_d;

  logic            advance;
  logic            do_req;
  logic            do_write;
  logic [IdxW-1:0] sel_idx;
  // Entries younger than this rank (extended by one bit) age by one.
  logic [IdxW:0]   age_limit;
  lookup_t         lookup;

  // The output register frees up when empty or taken this cycle.
  assign advance     = !rsp_valid_q || !rsp_stall_i;
  assign do_req      = in_valid_q && advance;
  assign req_stall_o = in_valid_q && !advance;

  lrutc_lookup u_lookup (
    .tag_i    (in_q.name_tag),
    .valid_i  (valid_q),
    .tags_i   (tags_q),
    .ranks_i  (ranks_q),
    .lookup_o (lookup)
  );

  always_comb begin
    rsp_d     = '0;
    valid_d   = valid_q;
    ranks_d   = ranks_q;
    fill_d    = fill_q;
    do_write  = 1'b0;
    sel_idx   = lookup.hit_idx;
    age_limit = {1'b0, ranks_q[lookup.hit_idx]};

    priority if (lookup.hit) begin
      rsp_d.hit = 1'b1;
    end else if (!in_q.fetch_ok) begin
      rsp_d.failed = 1'b1;
    end else if (fill_q != CntFull) begin
      // Fill the next never-used slot; every valid entry ages.
      do_write       = 1'b1;
      rsp_d.inserted = 1'b1;
      sel_idx        = fill_q[IdxW-1:0];
      age_limit      = (IdxW+1)'(Entries);
      fill_d         = fill_q + CntW'(1);
    end else begin
      // Reuse the oldest entry.
      do_write       = 1'b1;
      rsp_d.inserted = 1'b1;
      rsp_d.evicted  = 1'b1;
      sel_idx        = lookup.victim_idx;
      age_limit      = (IdxW+1)'(Entries - 1);
    end

    if (!rsp_d.failed) begin
      rsp_d.slot = SlotOutW'(sel_idx);
      for (int i = 0; i < Entries; i++) begin
        if (IdxW'(i) != sel_idx && valid_q[i] && ({1'b0, ranks_q[i]} < age_limit)) begin
          ranks_d[i] = ranks_q[i] + IdxW'(1);
        end
      end
      ranks_d[sel_idx] = '0;
      valid_d[sel_idx] = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
      valid_q     <= '0;
      fill_q      <= '0;
    end else begin
      if (!req_stall_o) begin
        in_valid_q <= req_valid_i;
      end
      if (advance) begin
        rsp_valid_q <= in_valid_q;
      end
      if (do_req) begin
        valid_q <= valid_d;
        fill_q  <= fill_d;
      end
    end
  end

  // Payload and directory contents
  always_ff @(posedge clk_i) begin
    if (req_valid_i && !req_stall_o) begin
      in_q <= req_i;
    end
    if (do_req) begin
      rsp_q   <= rsp_d;
      ranks_q <= ranks_d;
      if (do_write) begin
        tags_q[sel_idx] <= in_q.name_tag;
      end
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== hw/rtl/lrutc_lookup.sv =====
// ----------------------------------------------------------------------------
// lrutc_lookup
// Parallel tag compare over all entries and search for the oldest entry.
// ----------------------------------------------------------------------------
module lrutc_lookup import lrutc_pkg::*; (
  input  logic [TagBits-1:0]              tag_i,
  input  logic [Entries-1:0]              valid_i,
  input  logic [Entries-1:0][TagBits-1:0] tags_i,
  input  logic [Entries-1:0][IdxW-1:0]    ranks_i,
  output lookup_t                         lookup_o
);

  localparam logic [IdxW-1:0] OldestRank = IdxW'(Entries - 1);

  logic [Entries-1:0] match;
  logic [Entries-1:0] oldest;

  always_comb begin
    for (int i = 0; i < Entries; i++) begin
      match[i]  = valid_i[i] && (tags_i[i] == tag_i);
      oldest[i] = valid_i[i] && (ranks_i[i] == OldestRank);
    end
  end

  // Lowest index wins on both searches.
  always_comb begin
    lookup_o = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (match[i]) begin
        lookup_o.hit     = 1'b1;
        lookup_o.hit_idx = IdxW'(i);
      end
      if (oldest[i]) begin
        lookup_o.victim_idx = IdxW'(i);
      end
    end
  end

endmodule
